[sv/omwm_pkg.sv]
// Shared types and codes for the marker word manager.
package omwm_pkg;

  // Flag bits per entry are held in a 5-bit register
  localparam int ENTRY_BITS_W = 5;
  typedef logic [ENTRY_BITS_W-1:0] entry_bits_t;

  // Command opcodes
  localparam logic [1:0] OP_GET    = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_RETIRE = 2'd2;

  // Marker word selectors
  localparam logic [1:0] SEL_PROD = 2'd0;
  localparam logic [1:0] SEL_CORE = 2'd1;
  localparam logic [1:0] SEL_MOVE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NO_ROOM = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_PROD_ENTRY_BITS = 2'd0;
  localparam logic [1:0] CFG_CORE_ENTRY_BITS = 2'd1;
  localparam logic [1:0] CFG_MOVE_ENTRY_BITS = 2'd2;
  localparam logic [1:0] CFG_PROD_FLAG_LIMIT = 2'd3;

endpackage

[sv/omwm_entry_find.sv]
// Active entry search: lowest entry of a marker word whose live bit is set.
module omwm_entry_find #(
  parameter int WORD_BITS = 32
) (
  input  logic [WORD_BITS-1:0]        word,
  input  omwm_pkg::entry_bits_t       entry_bits,
  output logic                        found,
  output logic [$clog2(WORD_BITS)-1:0] pos
);

  localparam int PosW = $clog2(WORD_BITS);
  localparam int NumB = 1 << omwm_pkg::ENTRY_BITS_W;
  localparam int DiffW = ((PosW > omwm_pkg::ENTRY_BITS_W) ? PosW : omwm_pkg::ENTRY_BITS_W) + 1;

  // Bit p is a live bit for b flag bits when (b+1) divides (p+1)
  logic [WORD_BITS-1:0][NumB-1:0] div_tab;
  logic [WORD_BITS-1:0]           live_mask;
  logic [WORD_BITS-1:0]           cand;
  logic [WORD_BITS-1:0]           lowest;
  logic [PosW-1:0]                live_idx;
  logic [DiffW-1:0]               diff;

  for (genvar p = 0; p < WORD_BITS; p++) begin : g_bit
    for (genvar d = 0; d < NumB; d++) begin : g_div
      localparam bit DivOk = (((p + 1) % (d + 1)) == 0);
      assign div_tab[p][d] = DivOk;
    end
    assign live_mask[p] = div_tab[p][entry_bits];
  end

  // Isolate the lowest set live bit
  assign cand   = word & live_mask;
  assign lowest = cand & (~cand + WORD_BITS'(1));
  assign found  = |cand;

  // Encode the one-hot live bit position
  always_comb begin
    live_idx = '0;
    for (int p = 0; p < WORD_BITS; p++) begin
      if (lowest[p]) begin
        live_idx = live_idx | PosW'(p);
      end
    end
  end

  // Step back from the live bit to the start of the entry
  assign diff = DiffW'(live_idx) - DiffW'(entry_bits);
  assign pos  = found ? diff[PosW-1:0] : '0;

endmodule

[sv/otp_marker_word_manager_unit.sv]
// Top level of the write-once marker word manager.
//
//  channel  ports                                          handshake
//  -------  ---------------------------------------------  -------------------------
//  command  in_opcode, in_marker_select, in_flag_index     start && !busy
//  result   out_status, out_marker_value,                  out_valid, one cycle
//           out_active_found, out_word_after
//  config   cfg_index, cfg_data                            cfg_valid && cfg_ready
//
// One command word per cycle; busy stays low. Each taken command goes into the command
// register, then the search, update and re-search run into the result register.
// Synchronous reset sets every marker word to all ones and each configuration register to 3.
// The receiver cannot stall; each result is shown for exactly one cycle.
module otp_marker_word_manager_unit #(
  parameter int MARKER_WORD_BITS = 32,
  parameter int MARKER_COUNT     = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [1:0]  in_marker_select,
  input  logic [4:0]  in_flag_index,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_marker_value,
  output logic        out_active_found,
  output logic [31:0] out_word_after,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  localparam int NumWords = (MARKER_COUNT < 3) ? MARKER_COUNT : 3;
  localparam int PosW     = $clog2(MARKER_WORD_BITS);
  localparam int NumB     = 1 << omwm_pkg::ENTRY_BITS_W;
  localparam int SumW     = $clog2(MARKER_WORD_BITS + 2 * NumB + 1);
  localparam int ExtW     = (MARKER_WORD_BITS > 32) ? MARKER_WORD_BITS : 32;
  localparam logic [1:0]                  SelLimit = 2'(NumWords);
  localparam logic [MARKER_WORD_BITS-1:0] WordOne  = MARKER_WORD_BITS'(1);
  localparam logic [SumW-1:0]             WordLen  = SumW'(MARKER_WORD_BITS);

  // Configuration registers
  omwm_pkg::entry_bits_t eb_prod_r, eb_core_r, eb_move_r;
  logic [4:0]            flag_limit_r;

  // Marker word store
  logic [MARKER_WORD_BITS-1:0] words_r [NumWords];

  // Command register
  logic       item_valid_r;
  logic [1:0] op_r, sel_r;
  logic [4:0] ix_r;

  // Result register
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [31:0] out_marker_value_r;
  logic        out_active_found_r;
  logic [31:0] out_word_after_r;

  // Datapath
  logic                        sel_ok;
  logic [MARKER_WORD_BITS-1:0] w_cur, w_new;
  omwm_pkg::entry_bits_t       b_cur;
  logic                        found_pre, found_post;
  logic [PosW-1:0]             pos_pre, pos_post;
  logic [SumW-1:0]             set_pos, live_pos, retire_end;
  logic                        set_fits, retire_fits;
  logic [1:0]                  status_nxt;
  logic [ExtW-1:0]             field_ext, word_ext;
  logic [31:0]                 field_mask;
  logic [1:0]                  out_status_nxt;
  logic [31:0]                 out_marker_value_nxt, out_word_after_nxt;
  logic                        out_active_found_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eb_prod_r    <= omwm_pkg::ENTRY_BITS_W'(3);
      eb_core_r    <= omwm_pkg::ENTRY_BITS_W'(3);
      eb_move_r    <= omwm_pkg::ENTRY_BITS_W'(3);
      flag_limit_r <= 5'd3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        omwm_pkg::CFG_PROD_ENTRY_BITS: eb_prod_r    <= cfg_data;
        omwm_pkg::CFG_CORE_ENTRY_BITS: eb_core_r    <= cfg_data;
        omwm_pkg::CFG_MOVE_ENTRY_BITS: eb_move_r    <= cfg_data;
        omwm_pkg::CFG_PROD_FLAG_LIMIT: flag_limit_r <= cfg_data;
      endcase
    end
  end

  // Capture the command word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r  <= in_opcode;
      sel_r <= in_marker_select;
      ix_r  <= in_flag_index;
    end
  end

  // Select word and entry size
  assign sel_ok = (sel_r < SelLimit);

  always_comb begin
    w_cur = '1;
    for (int k = 0; k < NumWords; k++) begin
      if (sel_r == 2'(k)) begin
        w_cur = words_r[k];
      end
    end
  end

  always_comb begin
    unique case (sel_r)
      omwm_pkg::SEL_PROD: b_cur = eb_prod_r;
      omwm_pkg::SEL_CORE: b_cur = eb_core_r;
      default:            b_cur = eb_move_r;
    endcase
  end

  omwm_entry_find #(.WORD_BITS(MARKER_WORD_BITS)) u_find_pre (
    .word       (w_cur),
    .entry_bits (b_cur),
    .found      (found_pre),
    .pos        (pos_pre)
  );

  // Bit positions and room checks
  assign set_pos     = SumW'(pos_pre) + SumW'(ix_r);
  assign live_pos    = SumW'(pos_pre) + SumW'(b_cur);
  assign retire_end  = SumW'(pos_pre) + SumW'(2) * (SumW'(b_cur) + SumW'(1));
  assign set_fits    = (set_pos < WordLen);
  assign retire_fits = (retire_end <= WordLen);

  // Apply the command
  always_comb begin
    w_new      = w_cur;
    status_nxt = omwm_pkg::ST_OK;
    unique case (op_r)
      omwm_pkg::OP_GET: begin
        w_new = w_cur;
      end
      omwm_pkg::OP_SET: begin
        priority if (sel_r == omwm_pkg::SEL_PROD && ix_r >= flag_limit_r) begin
          status_nxt = omwm_pkg::ST_INVALID;
        end else if (!found_pre) begin
          status_nxt = omwm_pkg::ST_NO_ROOM;
        end else if (!set_fits) begin
          status_nxt = omwm_pkg::ST_INVALID;
        end else begin
          w_new = w_cur & ~(WordOne << set_pos[PosW-1:0]);
        end
      end
      omwm_pkg::OP_RETIRE: begin
        if (!found_pre || !retire_fits) begin
          status_nxt = omwm_pkg::ST_NO_ROOM;
        end else begin
          w_new = w_cur & ~(WordOne << live_pos[PosW-1:0]);
        end
      end
      default: begin
        status_nxt = omwm_pkg::ST_INVALID;
      end
    endcase
  end

  omwm_entry_find #(.WORD_BITS(MARKER_WORD_BITS)) u_find_post (
    .word       (w_new),
    .entry_bits (b_cur),
    .found      (found_post),
    .pos        (pos_post)
  );

  // Extract the active field of the updated word
  assign field_ext  = ExtW'(w_new >> pos_post);
  assign word_ext   = ExtW'(w_new);
  assign field_mask = ~(32'hFFFF_FFFF << b_cur);

  always_comb begin
    if (!sel_ok) begin
      out_status_nxt       = omwm_pkg::ST_INVALID;
      out_marker_value_nxt = 32'hFFFF_FFFF;
      out_active_found_nxt = 1'b0;
      out_word_after_nxt   = 32'd0;
    end else begin
      out_status_nxt       = status_nxt;
      out_marker_value_nxt = found_post ? (field_ext[31:0] & field_mask) : 32'hFFFF_FFFF;
      out_active_found_nxt = found_post;
      out_word_after_nxt   = word_ext[31:0];
    end
  end

  // Write back the selected marker word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NumWords; k++) begin
        words_r[k] <= '1;
      end
    end else if (item_valid_r && sel_ok) begin
      for (int k = 0; k < NumWords; k++) begin
        if (sel_r == 2'(k)) begin
          words_r[k] <= w_new;
        end
      end
    end
  end

  // Register the result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid_r) begin
      out_status_r       <= out_status_nxt;
      out_marker_value_r <= out_marker_value_nxt;
      out_active_found_r <= out_active_found_nxt;
      out_word_after_r   <= out_word_after_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_marker_value = out_marker_value_r;
  assign out_active_found = out_active_found_r;
  assign out_word_after   = out_word_after_r;

  // Every command in the command register yields exactly one result in the cycle after
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r == $past(item_valid_r))
    else $error("result strobe does not track the command register");

  // A missing live entry reads back as an all-ones field
  a_absent_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_active_found_r |-> out_marker_value_r == 32'hFFFF_FFFF)
    else $error("missing active entry must report all ones");

  // Marker bits are only ever cleared
  for (genvar k = 0; k < NumWords; k++) begin : g_chk
    a_bits_only_clear: assert property (@(posedge clk) disable iff (!rst_n)
      $past(rst_n) |-> (words_r[k] & ~$past(words_r[k])) == '0)
      else $error("marker word gained a set bit");
  end

endmodule
